FILE: src/psr_pkg.sv
// Shared types and constants for the parallax scroll ramp controller.
package psr_pkg;

   // Request codes carried in req_type.
   localparam logic [2:0] OP_TICK   = 3'd0;
   localparam logic [2:0] OP_SET    = 3'd1;
   localparam logic [2:0] OP_RAMP   = 3'd2;
   localparam logic [2:0] OP_ADD    = 3'd3;
   localparam logic [2:0] OP_CLEAR  = 3'd4;
   localparam logic [2:0] OP_REARM  = 3'd5;
   localparam logic [2:0] OP_VBLANK = 3'd6;

   // Result kinds carried in result_kind.
   localparam logic [2:0] KIND_POS    = 3'd0;
   localparam logic [2:0] KIND_FIRE   = 3'd1;
   localparam logic [2:0] KIND_LAYER  = 3'd2;
   localparam logic [2:0] KIND_ACK    = 3'd3;
   localparam logic [2:0] KIND_REJECT = 3'd4;

   localparam logic [15:0] STEP_UP   = 16'h0001;
   localparam logic [15:0] STEP_DOWN = 16'hFFFF;

   typedef struct packed {
      logic [2:0]  req_type;
      logic [15:0] speed_value;
      logic [7:0]  ramp_frames;
      logic [15:0] trigger_distance;
   } psr_req_type;

   typedef struct packed {
      logic [2:0]  result_kind;
      logic [7:0]  layer1_y;
      logic [7:0]  layer2_y;
      logic [7:0]  distance_px;
      logic [15:0] speed_now;
      logic [2:0]  fired_slot;
      logic        last;
   } psr_rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_EXEC,
      ST_DIV,
      ST_MOVE,
      ST_WALK_RD,
      ST_WALK_CMP,
      ST_POS,
      ST_SCAN,
      ST_ONE
   } psr_state_type;

   typedef struct packed {
      logic       take_req;
      logic       ramp_tick;
      logic       advance;
      logic       walk_start;
      logic       fire_set;
      logic       idx_inc;
      logic       scan_start;
      logic       emit_inc;
      logic       set_speed;
      logic       div_start;
      logic       ramp_commit;
      logic       add_slot;
      logic       clear_slots;
      logic       rearm;
      logic       clear_pending;
      logic       load_rsp;
      logic [2:0] rsp_kind;
      logic       rsp_last;
   } psr_cmd_type;

   typedef struct packed {
      logic [2:0] req_type;
      logic       frames_zero;
      logic       slots_full;
      logic       pending;
      logic       speed_zero;
      logic       div_done;
      logic       idx_end;
      logic       fire_hit;
      logic       mask_bit;
      logic       nf_zero;
      logic       fire_last;
   } psr_status_type;

endpackage

FILE: src/psr_div.sv
// Radix-2 restoring divider: 16-bit magnitude by 8-bit divisor, one bit per cycle.
module psr_div import psr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [15:0] dividend,
   input  logic [7:0]  divisor,
   output logic        done,
   output logic [15:0] quotient
);

   logic [4:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [7:0]  rem_ff, rem_in;
   logic [15:0] quo_ff, quo_in;
   logic [7:0]  dvs_ff, dvs_in;
   logic [8:0]  trial;
   logic        ge;

   assign trial = {rem_ff, quo_ff[15]};
   assign ge    = trial >= {1'b0, dvs_ff};

   always_comb begin
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         cnt_in  = '0;
         busy_in = 1'b1;
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         rem_in = ge ? 8'(trial - {1'b0, dvs_ff}) : trial[7:0];
         quo_in = {quo_ff[14:0], ge};
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd15) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

FILE: src/psr_dp.sv
// Datapath: scroll state, trigger slot memory, ramp divider and result register.
module psr_dp import psr_pkg::*; #(
   parameter int TRIGGER_SLOTS = 8
) (
   input  logic           clock,
   input  logic           reset,
   input  psr_cmd_type    cmd,
   output psr_status_type status,
   input  psr_req_type    req_data,
   output psr_rsp_type    rsp_data
);

   localparam int CW = $clog2(TRIGGER_SLOTS + 1);
   localparam int AW = (TRIGGER_SLOTS > 1) ? $clog2(TRIGGER_SLOTS) : 1;

   psr_req_type req_ff;
   psr_rsp_type rsp_ff;

   logic [15:0] layer1_pos_ff, layer2_pos_ff, speed_ff, target_ff, step_ff, dist_ff;
   logic [7:0]  layer1_lat_ff, layer2_lat_ff;
   logic        ramping_ff, pending_ff, diff_neg_ff;
   logic [CW-1:0] count_ff, idx_ff, nf_ff, emitted_ff;
   logic [TRIGGER_SLOTS-1:0] mask_ff;
   logic [TRIGGER_SLOTS-1:0] fired_ff;
   logic [15:0] slot_mem [TRIGGER_SLOTS];
   logic [15:0] rd_data_ff;

   logic [AW-1:0] idx_a, cnt_a;
   logic [15:0]   ramp_sum, l1_sum, l2_sum;
   logic          step_pos, step_neg, snap;
   logic [16:0]   diff;
   logic [15:0]   diff_mag;
   logic          div_done;
   logic [15:0]   div_quo, quo_signed, step_fixed;

   assign idx_a = idx_ff[AW-1:0];
   assign cnt_a = count_ff[AW-1:0];

   // Ramp step applied on a tick; the speed snaps once it reaches the target.
   assign ramp_sum = speed_ff + step_ff;
   assign step_pos = !step_ff[15] && (step_ff != '0);
   assign step_neg = step_ff[15];
   assign snap     = (step_pos && ramp_sum >= target_ff) || (step_neg && ramp_sum <= target_ff);

   assign l1_sum = layer1_pos_ff + speed_ff;
   assign l2_sum = layer2_pos_ff + {1'b0, speed_ff[15:1]};

   // Signed difference of target and speed, split into sign and magnitude.
   assign diff     = {req_ff.speed_value[15], req_ff.speed_value} - {speed_ff[15], speed_ff};
   assign diff_mag = diff[16] ? 16'(-diff) : diff[15:0];

   psr_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (diff_mag),
      .divisor  (req_ff.ramp_frames),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign quo_signed = diff_neg_ff ? 16'(-div_quo) : div_quo;
   assign step_fixed = (quo_signed != '0) ? quo_signed :
                       (req_ff.speed_value > speed_ff) ? STEP_UP : STEP_DOWN;

   always_ff @(posedge clock) begin
      if (reset) begin
         layer1_pos_ff <= '0;
         layer2_pos_ff <= '0;
         speed_ff      <= '0;
         target_ff     <= '0;
         step_ff       <= '0;
         ramping_ff    <= 1'b0;
         dist_ff       <= '0;
         layer1_lat_ff <= '0;
         layer2_lat_ff <= '0;
         pending_ff    <= 1'b1;
         count_ff      <= '0;
         idx_ff        <= '0;
         nf_ff         <= '0;
         emitted_ff    <= '0;
         mask_ff       <= '0;
         diff_neg_ff   <= 1'b0;
      end else begin
         if (cmd.ramp_tick && ramping_ff) begin
            speed_ff <= snap ? target_ff : ramp_sum;
            if (snap) begin
               ramping_ff <= 1'b0;
            end
         end
         if (cmd.set_speed) begin
            speed_ff   <= req_ff.speed_value;
            target_ff  <= req_ff.speed_value;
            ramping_ff <= 1'b0;
         end
         if (cmd.div_start) begin
            diff_neg_ff <= diff[16];
         end
         if (cmd.ramp_commit) begin
            target_ff  <= req_ff.speed_value;
            step_ff    <= step_fixed;
            ramping_ff <= 1'b1;
         end
         if (cmd.advance) begin
            layer1_pos_ff <= l1_sum;
            layer2_pos_ff <= l2_sum;
            dist_ff       <= dist_ff + speed_ff;
            layer1_lat_ff <= l1_sum[15:8];
            layer2_lat_ff <= l2_sum[15:8];
            pending_ff    <= 1'b1;
         end
         if (cmd.clear_pending) begin
            pending_ff <= 1'b0;
         end
         if (cmd.add_slot) begin
            count_ff <= count_ff + CW'(1);
         end
         if (cmd.clear_slots) begin
            count_ff <= '0;
         end
         if (cmd.walk_start) begin
            idx_ff  <= '0;
            nf_ff   <= '0;
            mask_ff <= '0;
         end
         if (cmd.scan_start) begin
            idx_ff     <= '0;
            emitted_ff <= '0;
         end
         if (cmd.idx_inc) begin
            idx_ff <= idx_ff + CW'(1);
         end
         if (cmd.fire_set) begin
            nf_ff          <= nf_ff + CW'(1);
            mask_ff[idx_a] <= 1'b1;
         end
         if (cmd.emit_inc) begin
            emitted_ff <= emitted_ff + CW'(1);
         end
      end
   end

   // Fired flags and slot distances are written before they are read.
   always_ff @(posedge clock) begin
      if (cmd.rearm) begin
         fired_ff <= '0;
      end else if (cmd.add_slot) begin
         fired_ff[cnt_a] <= 1'b0;
      end else if (cmd.fire_set) begin
         fired_ff[idx_a] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.add_slot) begin
         slot_mem[cnt_a] <= req_ff.trigger_distance;
      end
      rd_data_ff <= slot_mem[idx_a];
   end

   always_ff @(posedge clock) begin
      if (cmd.take_req) begin
         req_ff <= req_data;
      end
      if (cmd.load_rsp) begin
         rsp_ff.result_kind <= cmd.rsp_kind;
         rsp_ff.layer1_y    <= layer1_lat_ff;
         rsp_ff.layer2_y    <= layer2_lat_ff;
         rsp_ff.distance_px <= dist_ff[15:8];
         rsp_ff.speed_now   <= speed_ff;
         rsp_ff.fired_slot  <= (cmd.rsp_kind == KIND_FIRE) ? 3'(idx_ff) : 3'd0;
         rsp_ff.last        <= cmd.rsp_last;
      end
   end

   always_comb begin
      status.req_type    = req_ff.req_type;
      status.frames_zero = (req_ff.ramp_frames == '0);
      status.slots_full  = (count_ff >= CW'(TRIGGER_SLOTS));
      status.pending     = pending_ff;
      status.speed_zero  = (speed_ff == '0);
      status.div_done    = div_done;
      status.idx_end     = (idx_ff >= count_ff);
      status.fire_hit    = !fired_ff[idx_a] && ({8'd0, dist_ff[15:8]} >= rd_data_ff);
      status.mask_bit    = mask_ff[idx_a];
      status.nf_zero     = (nf_ff == '0);
      status.fire_last   = ({1'b0, emitted_ff} + (CW + 1)'(1)) == {1'b0, nf_ff};
   end

   assign rsp_data = rsp_ff;

endmodule

FILE: src/psr_ctrl.sv
// Controller state machine: sequences each command and the result channel.
module psr_ctrl import psr_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   input  psr_status_type status,
   output psr_cmd_type    cmd
);

   psr_state_type state_ff, state_in;
   logic [2:0]    kind_ff, kind_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          slot_free;

   // The result register may be reloaded in the cycle its item leaves.
   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      kind_in  = kind_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            kind_in  = KIND_ACK;
            state_in = ST_ONE;
            unique case (status.req_type)
               OP_TICK: state_in = ST_MOVE;
               OP_RAMP: begin
                  if (!status.frames_zero) begin
                     state_in = ST_DIV;
                  end
               end
               OP_ADD: begin
                  if (status.slots_full) begin
                     kind_in = KIND_REJECT;
                  end
               end
               OP_VBLANK: begin
                  if (status.pending) begin
                     kind_in = KIND_LAYER;
                  end
               end
               default: ;
            endcase
         end
         ST_DIV: begin
            if (status.div_done) begin
               state_in = ST_ONE;
            end
         end
         ST_MOVE: state_in = status.speed_zero ? ST_POS : ST_WALK_RD;
         ST_WALK_RD: state_in = status.idx_end ? ST_POS : ST_WALK_CMP;
         ST_WALK_CMP: state_in = ST_WALK_RD;
         ST_POS: begin
            if (slot_free) begin
               state_in = status.nf_zero ? ST_IDLE : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (status.mask_bit && slot_free && status.fire_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_ONE: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      unique case (state_ff)
         ST_IDLE: cmd.take_req = req_valid;
         ST_EXEC: begin
            unique case (status.req_type)
               OP_TICK: cmd.ramp_tick = 1'b1;
               OP_SET:  cmd.set_speed = 1'b1;
               OP_RAMP: begin
                  cmd.set_speed = status.frames_zero;
                  cmd.div_start = !status.frames_zero;
               end
               OP_ADD:    cmd.add_slot      = !status.slots_full;
               OP_CLEAR:  cmd.clear_slots   = 1'b1;
               OP_REARM:  cmd.rearm         = 1'b1;
               OP_VBLANK: cmd.clear_pending = status.pending;
               default: ;
            endcase
         end
         ST_DIV: cmd.ramp_commit = status.div_done;
         ST_MOVE: begin
            cmd.walk_start = 1'b1;
            cmd.advance    = !status.speed_zero;
         end
         ST_WALK_RD: ;
         ST_WALK_CMP: begin
            cmd.fire_set = status.fire_hit;
            cmd.idx_inc  = 1'b1;
         end
         ST_POS: begin
            cmd.load_rsp   = slot_free;
            cmd.rsp_kind   = KIND_POS;
            cmd.rsp_last   = status.nf_zero;
            cmd.scan_start = slot_free && !status.nf_zero;
         end
         ST_SCAN: begin
            cmd.rsp_kind = KIND_FIRE;
            cmd.rsp_last = status.fire_last;
            if (status.mask_bit) begin
               cmd.load_rsp = slot_free;
               cmd.emit_inc = slot_free;
               cmd.idx_inc  = slot_free;
            end else begin
               cmd.idx_inc = 1'b1;
            end
         end
         ST_ONE: begin
            cmd.load_rsp = slot_free;
            cmd.rsp_kind = kind_ff;
            cmd.rsp_last = 1'b1;
         end
         default: ;
      endcase
   end

   assign rsp_valid_in = cmd.load_rsp || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         kind_ff      <= KIND_ACK;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         kind_ff      <= kind_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

FILE: src/parallax_scroll_ramp_controller.sv
// Top level of the parallax scroll ramp controller: controller, datapath and checks.
// One command item is taken at a time; its results leave through a result register, so the
// next item is taken while the last result still waits. A ramp with a nonzero frame count
// runs the one-bit-per-cycle divider before its step is committed. A tick at nonzero speed
// advances the layers and walks the added trigger slots, reading each slot distance from
// the trigger memory and then comparing it; a tick at zero speed skips the walk. When
// triggers fire, a scan then emits a fire result for each fired slot. The position result
// and each fire result also wait for a free result register.
module parallax_scroll_ramp_controller import psr_pkg::*; #(
   parameter int TRIGGER_SLOTS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  psr_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output psr_rsp_type rsp_data
);

   psr_cmd_type    cmd;
   psr_status_type status;

   psr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   psr_dp #(
      .TRIGGER_SLOTS (TRIGGER_SLOTS)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .status   (status),
      .req_data (req_data),
      .rsp_data (rsp_data)
   );

   // A waiting result is never overwritten by a new one.
   assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> (!rsp_valid || rsp_ready))
      else $error("result register reloaded while its item was still waiting");

   // An accepted item is decoded before another is taken.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("second item taken before the first was decoded");

   // The divider only finishes while a ramp command holds the block busy.
   assert property (@(posedge clock) disable iff (reset)
      status.div_done |-> !req_ready)
      else $error("divider finished while the block was idle");

   // A fire result is only produced when the walk recorded at least one fire.
   assert property (@(posedge clock) disable iff (reset)
      (cmd.load_rsp && cmd.rsp_kind == KIND_FIRE) |-> !status.nf_zero)
      else $error("fire result without a recorded trigger");

endmodule
